[hdl/free_list_block_allocator_core_macros.svh]
// assertion helpers for the block allocator checker
`ifndef FREE_LIST_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FLA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define FLA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[hdl/fla_pkg.sv]
`timescale 1ns / 1ps

package fla_pkg;

  localparam int SIZE_W     = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_POOL_SIZE = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

[hdl/fla_link_ram.sv]
`timescale 1ns / 1ps

module fla_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/free_list_block_allocator_core.sv]
`timescale 1ns / 1ps
// fixed-size block allocator, free blocks kept as a lifo chain of block indices
// items: start with op (allocate or free) and free_index, taken when start is
//   high and busy is low
// results: one per item, shown for one cycle with done high: granted_index,
//   pool_empty, bad_index; the receiver cannot stall, so nothing waits
// a free or an allocate on an empty pool gives its result in the cycle
//   after acceptance and busy stays low, so such items can follow every cycle
// an allocate that pops a block reads the new head from the registered link
//   ram output, so it goes through ST_POP, busy high for a single cycle
// config: apb write of pool_size at address 0 rebuilds the chain
// reset and every pool_size write start a rebuild pass: one link written per
//   cycle over all POOL_DEPTH links, busy high; apb writes are still taken
// a freed index at or above the pool size is flagged and ignored; double
//   frees are not detected and push the block again

module free_list_block_allocator_core
  import fla_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [$clog2(POOL_DEPTH)-1:0] free_index,
  // result channel
  output logic                          done,
  output logic [$clog2(POOL_DEPTH)-1:0] granted_index,
  output logic                          pool_empty,
  output logic                          bad_index,
  // apb config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = IDX_W + 1;
  localparam int CMP_W  = (LINK_W > SIZE_W) ? LINK_W : SIZE_W;
  // end-of-chain marker, one past the last block
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(POOL_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   pool_size;
  logic [LINK_W-1:0]   head;
  logic [IDX_W-1:0]    clr_idx;

  logic                cfg_wr;
  logic                accept;
  logic [CMP_W-1:0]    size_ext;
  logic [CMP_W-1:0]    eff_size;
  logic                idx_ok;
  logic [LINK_W-1:0]   clr_succ;
  logic [LINK_W-1:0]   clr_link;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;

  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(pool_size);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // pool size saturates at the ram depth
  assign size_ext = CMP_W'(pool_size);
  assign eff_size = (size_ext > DEPTH_C) ? DEPTH_C : size_ext;
  assign idx_ok   = (CMP_W'(free_index) < eff_size);

  // rebuild pass: entry i links to i+1 while inside the pool
  assign clr_succ = LINK_W'(clr_idx) + LINK_W'(1);
  assign clr_link = (CMP_W'(clr_succ) < eff_size) ? clr_succ : NULL_LINK;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_index;
    ram_wdata = head;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = clr_link;
    end else if (accept && (op == OP_FREE) && idx_ok) begin
      // push: freed block links to the old head
      ram_we = 1'b1;
    end
  end

  // head is read every cycle; the data is used in the pop cycle
  fla_link_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pool_size <= POOL_SIZE_RESET;
      head      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        pool_size <= pwdata[SIZE_W-1:0];
        clr_idx   <= '0;
        state     <= ST_CLEAR;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_idx <= clr_idx + IDX_W'(1);
            if (clr_idx == LAST_IDX) begin
              head  <= (eff_size != '0) ? '0 : NULL_LINK;
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (accept) begin
              if (op == OP_FREE) begin
                done          <= 1'b1;
                granted_index <= '0;
                pool_empty    <= 1'b0;
                bad_index     <= !idx_ok;
                if (idx_ok) begin
                  head <= LINK_W'(free_index);
                end
              end else if (head >= NULL_LINK) begin
                // empty pool answers at once
                done          <= 1'b1;
                granted_index <= '0;
                pool_empty    <= 1'b1;
                bad_index     <= 1'b0;
              end else begin
                state <= ST_POP;
              end
            end
          end
          ST_POP: begin
            done          <= 1'b1;
            granted_index <= head[IDX_W-1:0];
            pool_empty    <= 1'b0;
            bad_index     <= 1'b0;
            head          <= ram_rdata;
            state         <= ST_IDLE;
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

[hdl/fla_chk.sv]
`timescale 1ns / 1ps
`include "free_list_block_allocator_core_macros.svh"

module fla_chk
  import fla_pkg::*;
#(
  parameter int POOL_DEPTH = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [$clog2(POOL_DEPTH)-1:0] granted_index,
  input logic                          pool_empty,
  input logic                          bad_index,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [CFG_ADDR_W-1:0]         paddr,
  input logic                          pready
);

  logic cfg_wr;
  logic flagged;

  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);
  assign flagged = pool_empty || bad_index;

  // a result never carries both flags
  `FLA_ASSERT_NOW(a_flags_excl, done, !(pool_empty && bad_index))

  // no index is granted with a flagged result
  `FLA_ASSERT_NOW(a_flag_zero_index, done && flagged, granted_index == '0)

  // an accepted item answers next cycle or holds the block busy
  `FLA_ASSERT_NEXT(a_item_progress, start && !busy, done || busy)

  // a pool size write starts the rebuild pass
  `FLA_ASSERT_NEXT(a_cfg_rebuild, cfg_wr, busy)

endmodule

bind free_list_block_allocator_core fla_chk #(.POOL_DEPTH(POOL_DEPTH)) u_fla_chk (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fla_pkg::*;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int IDX_MAX    = POOL_DEPTH - 1;
  localparam logic [SIZE_W-1:0] NULL_LINK = SIZE_W'(POOL_DEPTH);
  // any register index other than pool_size is ignored by the block
  localparam logic REG_UNUSED = ~REG_POOL_SIZE;
  // generous cycle budget: about twenty chain rebuilds plus two thousand items
  // with long sender gaps, taken several times over
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 130;

  // one result item: granted block, empty flag, bad index flag
  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic             empty;
    logic             bad;
  } alloc_result_t;

  // free chain predictor and the queue of results it expects
  class alloc_scoreboard;
    logic [SIZE_W-1:0] link_mem [POOL_DEPTH];
    logic [SIZE_W-1:0] head;
    logic [SIZE_W-1:0] blocks;
    alloc_result_t     pending[$];
    int                errors;

    function new();
      errors = 0;
      write_reg(REG_POOL_SIZE, CFG_DATA_W'(POOL_SIZE_RESET));
    endfunction

    // pool_size write: saturate to the depth and chain blocks in ascending order
    function void write_reg(logic reg_idx, logic [CFG_DATA_W-1:0] value);
      logic [SIZE_W-1:0] n;
      if (reg_idx != REG_POOL_SIZE) return;
      n = value[SIZE_W-1:0];
      if (n > POOL_DEPTH) n = SIZE_W'(POOL_DEPTH);
      blocks = n;
      for (int i = 0; i < POOL_DEPTH; i++)
        link_mem[i] = (i + 1 < n) ? SIZE_W'(i + 1) : NULL_LINK;
      head = (n > 0) ? '0 : NULL_LINK;
    endfunction

    // accepted item: pop or push the chain and queue the result it must give
    function alloc_result_t note_item(logic item_op, logic [IDX_W-1:0] idx);
      alloc_result_t r;
      r = '0;
      if (item_op == OP_ALLOC) begin
        if (head < POOL_DEPTH) begin
          r.granted = head[IDX_W-1:0];
          head = link_mem[head[IDX_W-1:0]];
        end else begin
          r.empty = 1'b1;
        end
      end else if (idx < blocks) begin
        // double frees are pushed again, possibly closing a loop in the chain
        link_mem[idx] = head;
        head = SIZE_W'(idx);
      end else begin
        r.bad = 1'b1;
      end
      pending = {pending, r};
      return r;
    endfunction

    function void check_result(logic [IDX_W-1:0] g, logic e, logic b);
      alloc_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result granted_index %0d pool_empty %0b bad_index %0b",
                 $time, g, e, b);
        return;
      end
      want = pending.pop_front();
      if (g !== want.granted) begin
        errors++;
        $display("%0t: granted_index expected %0d actual %0d", $time, want.granted, g);
      end
      if (e !== want.empty) begin
        errors++;
        $display("%0t: pool_empty expected %0b actual %0b", $time, want.empty, e);
      end
      if (b !== want.bad) begin
        errors++;
        $display("%0t: bad_index expected %0b actual %0b", $time, want.bad, b);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic                  busy;
  logic                  op         = OP_ALLOC;
  logic [IDX_W-1:0]      free_index = '0;
  logic                  done;
  logic [IDX_W-1:0]      granted_index;
  logic                  pool_empty;
  logic                  bad_index;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  alloc_scoreboard sb = new();
  // blocks handed out and not yet returned, so most frees are well formed
  logic [IDX_W-1:0] held[$];
  int unsigned cycle_count = 0;

  free_list_block_allocator_core #(.POOL_DEPTH(POOL_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .op(op), .free_index(free_index),
    .done(done), .granted_index(granted_index), .pool_empty(pool_empty),
    .bad_index(bad_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor: done marks a result for exactly one cycle, no back pressure
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(granted_index, pool_empty, bad_index);
  end

  // hold start high until the block takes the item, then predict it
  task automatic send_item(input logic item_op, input logic [IDX_W-1:0] idx,
                           output alloc_result_t r);
    start      <= 1'b1;
    op         <= item_op;
    free_index <= idx;
    do @(posedge clk); while (busy);
    r = sb.note_item(item_op, idx);
  endtask

  // stop sending and wait until every queued result is back
  task automatic wait_drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // two-phase apb write, register updated in the access cycle
  task automatic apb_write(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(reg_idx, value);
  endtask

  // new pool size once idle; upper data bits carry junk the block must drop
  task automatic set_pool(input logic [SIZE_W-1:0] size);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = size;
    wait_drain();
    apb_write(REG_POOL_SIZE, word);
    held.delete();
  endtask

  // random traffic: mostly allocates and frees of held blocks, some noise,
  // out of range indices around the pool boundary, and random double frees
  task automatic run_phase(input int idle_pct, input int alloc_pct, input int drain_at);
    alloc_result_t r;
    logic          item_op;
    logic [IDX_W-1:0] idx;
    int pick;
    int k;
    int v;
    int blocks_now;
    blocks_now = sb.blocks;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      pick    = $urandom_range(99);
      idx     = IDX_W'($urandom_range(IDX_MAX));  // junk on allocates, noise on frees
      item_op = OP_FREE;
      if (pick < alloc_pct) begin
        item_op = OP_ALLOC;
      end else if (pick < 88) begin
        if (held.size() != 0) begin
          k   = $urandom_range(held.size() - 1);
          idx = held[k];
          held.delete(k);
        end else if (blocks_now > 0) begin
          idx = IDX_W'($urandom_range(blocks_now - 1));
        end
      end else if (pick >= 95) begin
        // last block, first one past the end, one further
        v = blocks_now - 1 + $urandom_range(2);
        if (v < 0) v = 0;
        if (v > IDX_MAX) v = IDX_MAX;
        idx = IDX_W'(v);
      end
      send_item(item_op, idx, r);
      if (item_op == OP_ALLOC && !r.empty) held = {held, r.granted};
      // sender holds off mid-phase until the pipe is empty
      if (n == drain_at) wait_drain();
    end
  endtask

  initial begin
    alloc_result_t r;
    logic [SIZE_W-1:0] size;
    int idle_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset pool: pops in order, double free makes a self loop, top index
    send_item(OP_ALLOC, IDX_W'(IDX_MAX), r);
    send_item(OP_ALLOC, '0, r);
    send_item(OP_FREE, IDX_W'(1), r);
    send_item(OP_FREE, IDX_W'(1), r);
    send_item(OP_ALLOC, IDX_W'($urandom_range(IDX_MAX)), r);
    send_item(OP_ALLOC, IDX_W'($urandom_range(IDX_MAX)), r);
    send_item(OP_FREE, IDX_W'(IDX_MAX), r);
    send_item(OP_ALLOC, '0, r);
    send_item(OP_FREE, '0, r);
    send_item(OP_ALLOC, IDX_W'(IDX_MAX), r);

    // empty pool: every allocate empty, every free flagged
    set_pool('0);
    send_item(OP_ALLOC, '0, r);
    send_item(OP_FREE, '0, r);
    send_item(OP_FREE, IDX_W'(IDX_MAX), r);

    // single block pool
    set_pool(SIZE_W'(1));
    send_item(OP_ALLOC, '0, r);
    send_item(OP_ALLOC, '0, r);
    send_item(OP_FREE, IDX_W'(1), r);
    send_item(OP_FREE, '0, r);
    send_item(OP_ALLOC, '0, r);

    // write to an unused register leaves the pool alone
    wait_drain();
    apb_write(REG_UNUSED, 32'h0000_0007);
    send_item(OP_ALLOC, '0, r);

    // size above the depth saturates to the full pool
    set_pool(SIZE_W'(2047));
    send_item(OP_FREE, IDX_W'(IDX_MAX), r);
    send_item(OP_ALLOC, '0, r);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       size = SIZE_W'(POOL_DEPTH);
        1:       size = SIZE_W'(1);
        2:       size = SIZE_W'(2047);
        3:       size = '0;
        8:       size = SIZE_W'(POOL_DEPTH + 1);
        12:      size = SIZE_W'($urandom_range(49, POOL_DEPTH - 1));
        default: size = SIZE_W'($urandom_range(2, 48));
      endcase
      // sender gaps: light, then heavy, then none
      if (p < 5) idle_pct = 20;
      else if (p < 10) idle_pct = 69;
      else idle_pct = 0;
      set_pool(size);
      run_phase(idle_pct, $urandom_range(35, 60), (p == 6) ? 65 : -1);
    end

    wait_drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[free_list_block_allocator_core.f]
+incdir+hdl
hdl/fla_pkg.sv
hdl/fla_link_ram.sv
hdl/free_list_block_allocator_core.sv
hdl/fla_chk.sv
tb/sv/testbench.sv
